>>> hw/rtl/cfr_pkg.sv
// Package for the command frame receiver: frame geometry, configuration and
// frame summary types, and the velocity clamp function.
// No dependencies.
`timescale 1ns / 1ps

package cfr_pkg;

  localparam int FRAME_BYTES = 11;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CNT_W       = 5;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] CSUM_IDX = CNT_W'(FRAME_BYTES - 2);

  localparam logic signed [15:0] LIM_XY   = 16'sd1000;
  localparam logic signed [15:0] LIM_TURN = 16'sd2000;

  localparam logic [7:0] HEADER_RST = 8'd123;
  localparam logic [7:0] TAIL_RST   = 8'd125;
  localparam logic [7:0] MOTION_RST = 8'd0;

  typedef enum logic [1:0] {
    REG_HEADER = 2'd0,
    REG_TAIL   = 2'd1,
    REG_MOTION = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] header_code;
    logic [7:0] tail_code;
    logic [7:0] motion_mode_code;
  } cfr_cfg_t;

  // Summary of a frame that has passed its tail and checksum checks.
  typedef struct packed {
    logic              motion;
    logic [7:0]        mode;
    logic signed [15:0] word_x;
    logic signed [15:0] word_y;
    logic signed [15:0] word_turn;
  } cfr_frame_t;

  function automatic logic signed [11:0] clamp_word(input logic signed [15:0] w,
                                                    input logic signed [15:0] lim);
    logic signed [15:0] r;
    r = w;
    if (w < -lim) r = -lim;
    if (w > lim) r = lim;
    return r[11:0];
  endfunction

endpackage

>>> hw/rtl/cfr_if.sv
// Stream interfaces for the command frame receiver: received bytes in and
// decoded frame results out. Depends on nothing but the port widths.
`timescale 1ns / 1ps

interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         frame_mode;
  logic               motion_updated;
  logic signed [10:0] vel_x;
  logic signed [10:0] vel_y;
  logic signed [11:0] vel_turn;

  modport source (output valid, output frame_mode, output motion_updated,
                  output vel_x, output vel_y, output vel_turn, input ready);
  modport sink   (input valid, input frame_mode, input motion_updated,
                  input vel_x, input vel_y, input vel_turn, output ready);
endinterface

>>> hw/rtl/cfr_parser.sv
// Byte input register and frame parser: header search, byte counter,
// running XOR, frame buffer and the tail and checksum test.
// Depends on cfr_pkg and cfr_in_if.
`timescale 1ns / 1ps

module cfr_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfr_pkg::cfr_cfg_t   cfg_i,
  cfr_in_if.sink              rx_i,
  output logic                frame_valid_o,
  output cfr_pkg::cfr_frame_t frame_o,
  input  logic                frame_ready_i
);
  import cfr_pkg::*;

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_frame_q;
  logic [CNT_W-1:0] idx_q;
  logic [7:0]       xor_q;
  logic [7:0]       store_q [FRAME_BYTES];

  logic last_byte;
  logic good;
  logic advance;

  assign last_byte = in_frame_q && (idx_q == LAST_IDX);
  assign good      = last_byte && (in_byte_q == cfg_i.tail_code) &&
                     (store_q[FRAME_BYTES-2] == xor_q);

  assign frame_valid_o = in_valid_q && good;
  // A byte that completes a good frame waits until the result slot is free.
  assign advance       = in_valid_q && (!good || frame_ready_i);
  assign rx_i.ready    = !in_valid_q || advance;

  assign frame_o.motion    = (store_q[1] == cfg_i.motion_mode_code);
  assign frame_o.mode      = store_q[1];
  assign frame_o.word_x    = {store_q[3], store_q[4]};
  assign frame_o.word_y    = {store_q[5], store_q[6]};
  assign frame_o.word_turn = {store_q[7], store_q[8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      idx_q      <= '0;
      xor_q      <= '0;
    end else if (advance) begin
      if (!in_frame_q) begin
        if (in_byte_q == cfg_i.header_code) begin
          in_frame_q <= 1'b1;
          idx_q      <= CNT_W'(1);
          xor_q      <= in_byte_q;
        end
      end else begin
        if (idx_q < CSUM_IDX) begin
          xor_q <= xor_q ^ in_byte_q;
        end
        if (last_byte) begin
          in_frame_q <= 1'b0;
          idx_q      <= '0;
        end else begin
          idx_q <= idx_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_frame_q) begin
      store_q[idx_q[IDX_W-1:0]] <= in_byte_q;
    end
  end

endmodule

>>> hw/rtl/cfr_result.sv
// Velocity clamp, held velocities and the result register.
// Depends on cfr_pkg and cfr_out_if.
`timescale 1ns / 1ps

module cfr_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                frame_valid_i,
  input  cfr_pkg::cfr_frame_t frame_i,
  output logic                frame_ready_o,
  cfr_out_if.source           res_o
);
  import cfr_pkg::*;

  logic               out_valid_q;
  logic [7:0]         mode_q;
  logic               motion_q;
  logic signed [10:0] vel_x_q;
  logic signed [10:0] vel_y_q;
  logic signed [11:0] vel_turn_q;
  logic signed [10:0] held_x_q;
  logic signed [10:0] held_y_q;
  logic signed [11:0] held_turn_q;

  logic signed [11:0] cx, cy, ct;
  logic signed [10:0] vel_x_d, vel_y_d;
  logic signed [11:0] vel_turn_d;
  logic               load;

  assign cx = clamp_word(frame_i.word_x, LIM_XY);
  assign cy = clamp_word(frame_i.word_y, LIM_XY);
  assign ct = clamp_word(frame_i.word_turn, LIM_TURN);

  assign vel_x_d    = frame_i.motion ? cx[10:0] : held_x_q;
  assign vel_y_d    = frame_i.motion ? cy[10:0] : held_y_q;
  assign vel_turn_d = frame_i.motion ? ct : held_turn_q;

  assign frame_ready_o = !out_valid_q || res_o.ready;
  assign load          = frame_valid_i && frame_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_turn_q <= '0;
    end else begin
      if (frame_ready_o) begin
        out_valid_q <= frame_valid_i;
      end
      if (load) begin
        held_x_q    <= vel_x_d;
        held_y_q    <= vel_y_d;
        held_turn_q <= vel_turn_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q     <= frame_i.mode;
      motion_q   <= frame_i.motion;
      vel_x_q    <= vel_x_d;
      vel_y_q    <= vel_y_d;
      vel_turn_q <= vel_turn_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.frame_mode     = mode_q;
  assign res_o.motion_updated = motion_q;
  assign res_o.vel_x          = vel_x_q;
  assign res_o.vel_y          = vel_y_q;
  assign res_o.vel_turn       = vel_turn_q;

endmodule

>>> hw/rtl/command_frame_receiver_top.sv
// Top level of the command frame receiver: configuration registers, the
// parser and the result stage. Depends on cfr_pkg, cfr_if, cfr_parser, cfr_result.
//
//   Channel  Dir  Payload                                          Handshake
//   rx_i     in   rx_byte[7:0]                                     valid/ready
//   res_o    out  frame_mode, motion_updated, vel_x, vel_y, vel_turn valid/ready
//   cfg      in   cfg_idx_i[1:0], cfg_data_i[7:0]                  cfg_we_i
//
// One byte is accepted per cycle while no good frame waits on a stalled result; the last
// frame byte reaches its result through the input register, then the result register.
// Reset is asynchronous and active low; it clears the parser state, the held
// velocities and the configuration to its defaults.
// A stalled result only blocks input when a byte that completes a good frame
// is waiting; other bytes keep flowing into the parser.
`timescale 1ns / 1ps

module command_frame_receiver_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  cfr_in_if.sink     rx_i,
  cfr_out_if.source  res_o
);
  import cfr_pkg::*;

  cfr_cfg_t   cfg_q;
  cfr_frame_t frame;
  logic       frame_valid;
  logic       frame_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_code      <= HEADER_RST;
      cfg_q.tail_code        <= TAIL_RST;
      cfg_q.motion_mode_code <= MOTION_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HEADER: cfg_q.header_code      <= cfg_data_i;
        REG_TAIL:   cfg_q.tail_code        <= cfg_data_i;
        REG_MOTION: cfg_q.motion_mode_code <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cfr_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .rx_i          (rx_i),
    .frame_valid_o (frame_valid),
    .frame_o       (frame),
    .frame_ready_i (frame_ready)
  );

  cfr_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_i       (frame),
    .frame_ready_o (frame_ready),
    .res_o         (res_o)
  );

  a_frame_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid && frame_ready |=> res_o.valid)
    else $error("accepted frame did not reach the result register");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid && !frame_ready |-> !rx_i.ready)
    else $error("input accepted while a good frame waits");

  a_xy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ($signed(res_o.vel_x) >= -11'sd1000) &&
                    ($signed(res_o.vel_x) <= 11'sd1000) &&
                    ($signed(res_o.vel_y) >= -11'sd1000) &&
                    ($signed(res_o.vel_y) <= 11'sd1000))
    else $error("planar velocity out of range");

  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ($signed(res_o.vel_turn) >= -12'sd2000) &&
                    ($signed(res_o.vel_turn) <= 12'sd2000))
    else $error("rotation rate out of range");

endmodule

>>> dv/command_frame_receiver_top_tb.sv
// Self-checking testbench for command_frame_receiver_top: sends byte streams of good,
// corrupted and truncated frames and checks every decoded result against a predictor.
// Depends on cfr_pkg, cfr_if and the RTL of the receiver.
`timescale 1ns / 1ps

module command_frame_receiver_top_tb;
  import cfr_pkg::*;

  localparam int         STALL_LIMIT   = 2000;
  localparam logic [1:0] REG_SPARE_IDX = 2'd3;   // beyond the register list

  typedef struct packed {
    logic [7:0]         mode;
    logic               motion;
    logic signed [10:0] vx;
    logic signed [10:0] vy;
    logic signed [11:0] vt;
  } frame_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  cfr_in_if  rx_if ();
  cfr_out_if res_if ();

  command_frame_receiver_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  // Predictor copy of the configuration and parser state.
  logic [7:0]         cfg_header;
  logic [7:0]         cfg_tail;
  logic [7:0]         cfg_motion;
  logic               pr_in_frame;
  logic [4:0]         pr_idx;
  logic [7:0]         pr_xor;
  logic [7:0]         pr_frame [FRAME_BYTES];
  logic signed [10:0] held_vx;
  logic signed [10:0] held_vy;
  logic signed [11:0] held_vt;

  frame_result_t pending_frames[$];
  int            error_count;
  int            quiet_cycles;
  bit            idling_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [15:0] saturate_word(input logic [7:0] hi,
                                                       input logic [7:0] lo,
                                                       input int lim);
    int v;
    v = int'($signed({hi, lo}));
    if (v < -lim) v = -lim;
    if (v > lim) v = lim;
    return 16'(v);
  endfunction

  function automatic void predict_rx_byte(input logic [7:0] b);
    frame_result_t    r;
    logic signed [15:0] w;
    if (!pr_in_frame) begin
      if (b == cfg_header) begin
        pr_frame[0] = b;
        pr_xor      = b;
        pr_idx      = 5'd1;
        pr_in_frame = 1'b1;
      end
      return;
    end
    if (pr_idx < FRAME_BYTES) pr_frame[pr_idx] = b;
    if (pr_idx < FRAME_BYTES - 2) pr_xor ^= b;
    pr_idx = pr_idx + 5'd1;
    if (pr_idx != 0 && pr_idx < FRAME_BYTES) return;
    pr_in_frame = 1'b0;
    pr_idx      = 5'd0;
    if (pr_frame[FRAME_BYTES-1] != cfg_tail || pr_frame[FRAME_BYTES-2] != pr_xor) return;
    r.mode   = pr_frame[1];
    r.motion = (pr_frame[1] == cfg_motion);
    if (r.motion) begin
      w       = saturate_word(pr_frame[3], pr_frame[4], 1000);
      held_vx = w[10:0];
      w       = saturate_word(pr_frame[5], pr_frame[6], 1000);
      held_vy = w[10:0];
      w       = saturate_word(pr_frame[7], pr_frame[8], 2000);
      held_vt = w[11:0];
    end
    r.vx = held_vx;
    r.vy = held_vy;
    r.vt = held_vt;
    pending_frames.push_back(r);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (idling_on && $urandom_range(99) < 8) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    // The transaction completes at the rising edge after a low phase with ready high.
    do @(negedge clk_i); while (!rx_if.ready);
    @(posedge clk_i);
    predict_rx_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] mode, input logic [15:0] wx,
                            input logic [15:0] wy, input logic [15:0] wt,
                            input logic [7:0] spare, input bit bad_csum, input bit bad_tail);
    logic [7:0] frame [FRAME_BYTES];
    logic [7:0] sum;
    foreach (frame[i]) frame[i] = 8'($urandom_range(255));
    frame[0] = cfg_header;
    frame[1] = mode;
    frame[2] = spare;
    frame[3] = wx[15:8];
    frame[4] = wx[7:0];
    frame[5] = wy[15:8];
    frame[6] = wy[7:0];
    frame[7] = wt[15:8];
    frame[8] = wt[7:0];
    sum = 8'd0;
    for (int i = 0; i < FRAME_BYTES - 2; i++) sum ^= frame[i];
    frame[FRAME_BYTES-2] = bad_csum ? sum ^ 8'($urandom_range(255, 1)) : sum;
    frame[FRAME_BYTES-1] = bad_tail ? cfg_tail ^ 8'($urandom_range(255, 1)) : cfg_tail;
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  function automatic logic [15:0] pick_word(input int lim);
    case ($urandom_range(7))
      0:       return 16'(lim);
      1:       return 16'(lim + 1);
      2:       return 16'(-lim);
      3:       return 16'(-lim - 1);
      4:       return 16'h7FFF;
      5:       return 16'h8000;
      6:       return 16'(int'($urandom_range(2 * lim)) - lim);
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_HEADER) cfg_header = data;
    else if (idx == REG_TAIL) cfg_tail = data;
    else if (idx == REG_MOTION) cfg_motion = data;
    @(posedge clk_i);
  endtask

  // Lets every expected result arrive, then waits out the pipeline so that
  // a frame which produces nothing has also left the block.
  task automatic settle_block();
    rx_if.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_saturating_motion_frame();
    // The header value as the spare byte must be taken as payload.
    send_frame(cfg_motion, 16'h7FFF, 16'h8000, 16'hF82F, cfg_header, 1'b0, 1'b0);
  endtask

  task automatic test_dropped_frame_keeps_velocity();
    send_frame(cfg_motion, 16'h0001, 16'h0002, 16'h0003, 8'h00, 1'b0, 1'b1);
    send_frame(~cfg_motion, 16'h0004, 16'h0005, 16'h0006, 8'hFF, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_frames);
    int kind;
    for (int f = 0; f < n_frames; f++) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        send_frame(cfg_motion, pick_word(1000), pick_word(1000), pick_word(2000),
                   8'($urandom_range(255)), 1'b0, 1'b0);
      end else if (kind < 75) begin
        send_frame(8'($urandom_range(255)), pick_word(1000), pick_word(1000),
                   pick_word(2000), 8'($urandom_range(255)), 1'b0, 1'b0);
      end else if (kind < 83) begin
        send_frame(cfg_motion, pick_word(1000), pick_word(1000), pick_word(2000),
                   8'($urandom_range(255)), 1'b1, 1'b0);
      end else if (kind < 90) begin
        send_frame(cfg_motion, pick_word(1000), pick_word(1000), pick_word(2000),
                   8'($urandom_range(255)), 1'b0, 1'b1);
      end else if (kind < 95) begin
        // Truncated frame: the next frame's bytes are swallowed as its payload.
        send_byte(cfg_header);
        repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end
    end
    settle_block();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_HEADER, 8'h00);
    write_reg(REG_TAIL, 8'hFF);
    write_reg(REG_MOTION, 8'hFF);
    idling_on = 1'b0;
    test_random_traffic(20);
    idling_on = 1'b1;
    write_reg(REG_HEADER, 8'hFF);
    write_reg(REG_TAIL, 8'h00);
    write_reg(REG_MOTION, 8'h00);
    test_random_traffic(15);
  endtask

  task automatic test_random_config();
    write_reg(REG_HEADER, 8'($urandom_range(255)));
    write_reg(REG_TAIL, 8'($urandom_range(255)));
    write_reg(REG_MOTION, 8'($urandom_range(255)));
    test_random_traffic(15);
  endtask

  task automatic test_spare_register_ignored();
    write_reg(REG_HEADER, HEADER_RST);
    write_reg(REG_TAIL, TAIL_RST);
    write_reg(REG_MOTION, MOTION_RST);
    write_reg(REG_SPARE_IDX, 8'($urandom_range(255)));
    test_random_traffic(12);
  endtask

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expected,
               actual);
      error_count++;
    end
  endtask

  // Result checker and stall counter, sampled in the low phase of the clock.
  initial begin
    frame_result_t exp_r;
    quiet_cycles = 0;
    forever begin
      @(negedge clk_i);
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (res_if.valid && res_if.ready) begin
        if (pending_frames.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual mode %0d", $time,
                   res_if.frame_mode);
          error_count++;
        end else begin
          exp_r = pending_frames.pop_front();
          check_field("frame_mode", exp_r.mode, res_if.frame_mode);
          check_field("motion_updated", exp_r.motion, res_if.motion_updated);
          check_field("vel_x", int'(exp_r.vx), int'(res_if.vel_x));
          check_field("vel_y", int'(exp_r.vy), int'(res_if.vel_y));
          check_field("vel_turn", int'(exp_r.vt), int'(res_if.vel_turn));
        end
      end
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= !(idling_on && $urandom_range(99) < 8);
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("** command_frame_receiver_top: FAILED **");
    $finish;
  end

  initial begin
    error_count   = 0;
    idling_on     = 1'b1;
    cfg_header    = HEADER_RST;
    cfg_tail      = TAIL_RST;
    cfg_motion    = MOTION_RST;
    pr_in_frame   = 1'b0;
    pr_idx        = 5'd0;
    pr_xor        = 8'd0;
    held_vx       = '0;
    held_vy       = '0;
    held_vt       = '0;
    foreach (pr_frame[i]) pr_frame[i] = 8'd0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_HEADER;
    cfg_data_i    <= 8'd0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_saturating_motion_frame();
    test_dropped_frame_keeps_velocity();
    settle_block();
    test_random_traffic(27);
    test_config_extremes();
    test_random_config();
    test_spare_register_ignored();

    settle_block();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** command_frame_receiver_top: PASSED **");
    end else begin
      $display("** command_frame_receiver_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_if.sv
hw/rtl/cfr_parser.sv
hw/rtl/cfr_result.sv
hw/rtl/command_frame_receiver_top.sv
dv/command_frame_receiver_top_tb.sv
